// ===== hw/rtl/pwbs_pkg.sv =====
package pwbs_pkg;

   localparam int MAX_BITS_DEF = 128;

   localparam int LOAD_PTR_W = 4;
   localparam int BYTE_W     = 8;
   localparam int HIGH_W     = 16;
   localparam int TICK_W     = 24;
   localparam int COUNT_W    = 8;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = 1;
   localparam int QUEUE_CW    = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_ONE_HIGH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_HIGH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PAUSE     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BITS      = 3'd4;

   typedef enum logic {
      OP_LOAD,
      OP_TICK
   } op_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_BITS,
      PH_PAUSE
   } phase_type;

   typedef struct packed {
      op_type             op;
      logic [BYTE_W-1:0]  data_byte;
      logic               last_byte;
   } item_type;

   typedef struct packed {
      logic [HIGH_W-1:0]  one_high_ticks;
      logic [HIGH_W-1:0]  zero_high_ticks;
      logic [HIGH_W-1:0]  bit_period_ticks;
      logic [TICK_W-1:0]  pause_ticks;
      logic [COUNT_W-1:0] bits_to_send;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      one_high_ticks:   16'd200,
      zero_high_ticks:  16'd100,
      bit_period_ticks: 16'd300,
      pause_ticks:      24'd1200000,
      bits_to_send:     8'd120
   };

endpackage

// ===== hw/rtl/pwbs_if.sv =====
interface pwbs_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, func, data_byte, last_byte, input ready);
   modport sink   (input valid, func, data_byte, last_byte, output ready);
endinterface

interface pwbs_rsp_if;
   logic valid;
   logic ready;
   logic line_level;
   logic busy_res;
   logic done_res;

   modport source (output valid, line_level, busy_res, done_res, input ready);
   modport sink   (input valid, line_level, busy_res, done_res, output ready);
endinterface

// ===== hw/rtl/pulse_width_bit_serializer.sv =====
// pulse-width serial line encoder
// req_chan carries one request per clock: a message byte load (func 0) or
// one timer tick of the output waveform (func 1). every request gives
// exactly one response on rsp_chan with the line level for that tick,
// busy while bits or the closing pause go out, and done on the tick that
// ends the pause. loading the byte marked last starts a transmission.
// csr_we with csr_index and csr_wdata sets the bit timing, pause length
// and bit count; write them only while the line is idle.
// throughput: one request per clock while responses are taken. a request
// passes through the input register, the queue and the output register
// before its response is presented.
// reset returns the timing registers to their defaults, empties the queue
// and puts the line in idle; the message store keeps its old contents.
// a stalled receiver holds the response; the two-entry queue and the input
// register then fill and req_chan.ready drops until responses are taken.
module pulse_width_bit_serializer #(
   parameter int MAX_BITS = pwbs_pkg::MAX_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   pwbs_req_if.sink                         req_chan,
   pwbs_rsp_if.source                       rsp_chan,
   input  logic                             csr_we,
   input  logic [pwbs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pwbs_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import pwbs_pkg::*;

   cfg_type  cfg_ff;
   cfg_type  cfg_in;
   logic     push_valid;
   item_type push_item;
   logic     push_ready;
   logic     pop_valid;
   item_type pop_item;
   logic     pop_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ONE_HIGH:  cfg_in.one_high_ticks   = csr_wdata[HIGH_W-1:0];
            CSR_ZERO_HIGH: cfg_in.zero_high_ticks  = csr_wdata[HIGH_W-1:0];
            CSR_PERIOD:    cfg_in.bit_period_ticks = csr_wdata[HIGH_W-1:0];
            CSR_PAUSE:     cfg_in.pause_ticks      = csr_wdata[TICK_W-1:0];
            CSR_BITS:      cfg_in.bits_to_send     = csr_wdata[COUNT_W-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pwbs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready)
   );

   pwbs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_ready  (pop_ready)
   );

   pwbs_back #(
      .MAX_BITS (MAX_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_item  (pop_item),
      .pop_ready (pop_ready),
      .rsp       (rsp_chan)
   );

endmodule

// ===== hw/rtl/pwbs_front.sv =====
module pwbs_front (
   input  logic               clock,
   input  logic               reset,
   pwbs_req_if.sink           req,
   output logic               push_valid,
   output pwbs_pkg::item_type push_item,
   input  logic               push_ready
);
   import pwbs_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;
   item_type item_in;
   item_type item_new;
   logic     accept;

   assign req.ready  = !valid_ff || push_ready;
   assign accept     = req.valid && req.ready;
   assign push_valid = valid_ff;
   assign push_item  = item_ff;

   // classify the request
   always_comb begin
      item_new.op        = req.func ? OP_TICK : OP_LOAD;
      item_new.data_byte = req.data_byte;
      item_new.last_byte = req.last_byte;
   end

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (accept) begin
         valid_in = 1'b1;
         item_in  = item_new;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

endmodule

// ===== hw/rtl/pwbs_queue.sv =====
module pwbs_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  pwbs_pkg::item_type push_item,
   output logic               push_ready,
   output logic               pop_valid,
   output pwbs_pkg::item_type pop_item,
   input  logic               pop_ready
);
   import pwbs_pkg::*;

   item_type              slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff;
   logic [QUEUE_AW-1:0]   wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff;
   logic [QUEUE_AW-1:0]   rd_ptr_in;
   logic [QUEUE_CW-1:0]   count_ff;
   logic [QUEUE_CW-1:0]   count_in;
   logic                  push;
   logic                  pop;

   assign push_ready = count_ff != QUEUE_CW'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      count_in  = count_ff + QUEUE_CW'(push) - QUEUE_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== hw/rtl/pwbs_back.sv =====
module pwbs_back #(
   parameter int MAX_BITS = pwbs_pkg::MAX_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  pwbs_pkg::cfg_type  cfg,
   input  logic               pop_valid,
   input  pwbs_pkg::item_type pop_item,
   output logic               pop_ready,
   pwbs_rsp_if.source         rsp
);
   import pwbs_pkg::*;

   localparam int ROWS_ALL  = (MAX_BITS + BYTE_W - 1) / BYTE_W;
   localparam int ROWS_MAX  = 1 << LOAD_PTR_W;
   localparam int ROWS      = (ROWS_ALL > ROWS_MAX) ? ROWS_MAX : ROWS_ALL;
   localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int LIMIT_CAP = (MAX_BITS > 255) ? 255 : MAX_BITS;

   phase_type              phase_ff;
   phase_type              phase_in;
   logic [LOAD_PTR_W-1:0]  load_ptr_ff;
   logic [LOAD_PTR_W-1:0]  load_ptr_in;
   logic [COUNT_W-1:0]     bit_pos_ff;
   logic [COUNT_W-1:0]     bit_pos_in;
   logic [TICK_W-1:0]      tick_ff;
   logic [TICK_W-1:0]      tick_in;
   logic [BYTE_W-1:0]      store_ff [ROWS];

   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic                   line_ff;
   logic                   line_in;
   logic                   busy_ff;
   logic                   busy_in;
   logic                   done_ff;
   logic                   done_in;

   logic                   take;
   logic                   is_load;
   logic                   is_tick;
   logic                   store_we;
   logic [COUNT_W-1:0]     bits_n;
   logic [COUNT_W-1:0]     limit;
   logic [4:0]             row_sel;
   logic [BYTE_W-1:0]      cur_row;
   logic                   cur_bit;
   logic [HIGH_W-1:0]      high_ticks;
   logic [TICK_W:0]        tick_inc;
   logic                   period_end;
   logic                   pause_end;
   logic [COUNT_W-1:0]     bit_pos_inc;
   logic                   last_bit;
   logic                   line_hit;

   assign take      = pop_valid && (!rsp_valid_ff || rsp.ready);
   assign pop_ready = take;
   assign is_load   = pop_item.op == OP_LOAD;
   assign is_tick   = pop_item.op == OP_TICK;

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.line_level = line_ff;
   assign rsp.busy_res   = busy_ff;
   assign rsp.done_res   = done_ff;

   // bit count, at least one and at most MAX_BITS or 255, whichever is smaller
   always_comb begin
      bits_n = (cfg.bits_to_send == '0) ? COUNT_W'(1) : cfg.bits_to_send;
      limit  = (bits_n > COUNT_W'(LIMIT_CAP)) ? COUNT_W'(LIMIT_CAP) : bits_n;
   end

   always_comb begin
      row_sel     = bit_pos_ff[COUNT_W-1:3];
      cur_row     = (int'(row_sel) < ROWS) ? store_ff[row_sel[ROW_W-1:0]] : '0;
      cur_bit     = cur_row[3'd7 - bit_pos_ff[2:0]];
      high_ticks  = cur_bit ? cfg.one_high_ticks : cfg.zero_high_ticks;
      tick_inc    = {1'b0, tick_ff} + (TICK_W + 1)'(1);
      period_end  = tick_inc >= (TICK_W + 1)'(cfg.bit_period_ticks);
      pause_end   = tick_inc >= {1'b0, cfg.pause_ticks};
      bit_pos_inc = bit_pos_ff + COUNT_W'(1);
      last_bit    = bit_pos_inc >= limit;
      line_hit    = tick_ff < TICK_W'(high_ticks);
      store_we    = take && is_load && (phase_ff == PH_IDLE) &&
                    (int'(load_ptr_ff) < ROWS);
   end

   always_comb begin
      phase_in = phase_ff;
      if (take) begin
         case (phase_ff)
            PH_IDLE: begin
               if (is_load && pop_item.last_byte) begin
                  phase_in = PH_BITS;
               end
            end
            PH_BITS: begin
               if (is_tick && period_end && last_bit) begin
                  phase_in = PH_PAUSE;
               end
            end
            PH_PAUSE: begin
               if (is_tick && pause_end) begin
                  phase_in = PH_IDLE;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_comb begin
      load_ptr_in  = load_ptr_ff;
      bit_pos_in   = bit_pos_ff;
      tick_in      = tick_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      line_in      = line_ff;
      busy_in      = busy_ff;
      done_in      = done_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
         line_in      = 1'b0;
         busy_in      = 1'b0;
         done_in      = 1'b0;
         case (phase_ff)
            PH_IDLE: begin
               if (is_load) begin
                  load_ptr_in = load_ptr_ff + LOAD_PTR_W'(1);
                  if (pop_item.last_byte) begin
                     load_ptr_in = '0;
                     bit_pos_in  = '0;
                     tick_in     = '0;
                     busy_in     = 1'b1;
                  end
               end
            end
            PH_BITS: begin
               busy_in = 1'b1;
               if (is_tick) begin
                  line_in = line_hit;
                  tick_in = period_end ? '0 : tick_inc[TICK_W-1:0];
                  if (period_end) begin
                     bit_pos_in = bit_pos_inc;
                  end
               end
            end
            PH_PAUSE: begin
               busy_in = 1'b1;
               if (is_tick) begin
                  tick_in = pause_end ? '0 : tick_inc[TICK_W-1:0];
                  if (pause_end) begin
                     bit_pos_in = '0;
                     done_in    = 1'b1;
                  end
               end
            end
            default: begin
               busy_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         load_ptr_ff  <= '0;
         bit_pos_ff   <= '0;
         tick_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         load_ptr_ff  <= load_ptr_in;
         bit_pos_ff   <= bit_pos_in;
         tick_ff      <= tick_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      line_ff <= line_in;
      busy_ff <= busy_in;
      done_ff <= done_in;
   end

   // message store, msb of each byte first
   always_ff @(posedge clock) begin
      if (store_we) begin
         store_ff[load_ptr_ff[ROW_W-1:0]] <= pop_item.data_byte;
      end
   end

endmodule

// ===== dv/pulse_width_bit_serializer_tb.sv =====
module pulse_width_bit_serializer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pwbs_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 1000000;
   localparam int unsigned RANDOM_ITEMS = 500;
   localparam int unsigned DRAIN_CYCLES = 8;

   typedef struct packed {
      logic line_level;
      logic busy_res;
      logic done_res;
   } line_result_type;

   class line_scoreboard;
      cfg_type                 timing;
      logic [MAX_BITS_DEF-1:0] message_bits;
      logic [LOAD_PTR_W-1:0]   load_slot;
      logic [COUNT_W-1:0]      bit_index;
      int unsigned             tick_cnt;
      phase_type               phase;
      line_result_type         expected_lines[$];
      int unsigned             errors;
      int unsigned             checked;
      int unsigned             transmissions;

      function new();
         timing        = CFG_RESET;
         message_bits  = '0;
         load_slot     = '0;
         bit_index     = '0;
         tick_cnt      = 0;
         phase         = PH_IDLE;
         errors        = 0;
         checked       = 0;
         transmissions = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_ONE_HIGH:  timing.one_high_ticks   = val[HIGH_W-1:0];
            CSR_ZERO_HIGH: timing.zero_high_ticks  = val[HIGH_W-1:0];
            CSR_PERIOD:    timing.bit_period_ticks = val[HIGH_W-1:0];
            CSR_PAUSE:     timing.pause_ticks      = val[TICK_W-1:0];
            CSR_BITS:      timing.bits_to_send     = val[COUNT_W-1:0];
            default: ;
         endcase
      endfunction

      function int unsigned bits_per_frame();
         int unsigned n;
         n = timing.bits_to_send;
         if (n == 0) n = 1;
         if (n > MAX_BITS_DEF) n = MAX_BITS_DEF;
         return n;
      endfunction

      // returns 0 when the request is a load ignored during a transmission
      function bit note_request(op_type op, logic [BYTE_W-1:0] data, logic last);
         line_result_type r;
         int unsigned     high_len;
         int unsigned     pos;
         bit              effective;
         r         = '0;
         effective = 1'b1;
         if (op == OP_LOAD) begin
            if (phase == PH_IDLE) begin
               for (int k = 0; k < 8; k++) begin
                  message_bits[int'(load_slot) * 8 + k] = data[7-k];
               end
               load_slot = load_slot + 1'b1;
               if (last) begin
                  load_slot = '0;
                  bit_index = '0;
                  tick_cnt  = 0;
                  phase     = PH_BITS;
                  r.busy_res = 1'b1;
                  transmissions++;
               end
            end else begin
               r.busy_res = 1'b1;
               effective  = 1'b0;
            end
         end else if (phase == PH_BITS) begin
            pos = bit_index;
            if (pos >= MAX_BITS_DEF) pos = MAX_BITS_DEF - 1;
            high_len = message_bits[pos] ? timing.one_high_ticks : timing.zero_high_ticks;
            r.line_level = (tick_cnt < high_len);
            r.busy_res   = 1'b1;
            tick_cnt++;
            if (tick_cnt >= timing.bit_period_ticks) begin
               tick_cnt  = 0;
               bit_index = bit_index + 1'b1;
               if (bit_index >= bits_per_frame()) phase = PH_PAUSE;
            end
         end else if (phase == PH_PAUSE) begin
            r.busy_res = 1'b1;
            tick_cnt++;
            if (tick_cnt >= timing.pause_ticks) begin
               tick_cnt   = 0;
               bit_index  = '0;
               phase      = PH_IDLE;
               r.done_res = 1'b1;
            end
         end
         expected_lines.push_back(r);
         return effective;
      endfunction

      function void check_response(logic line_level, logic busy_res, logic done_res);
         line_result_type e;
         if (expected_lines.size() == 0) begin
            $error("response with no request outstanding");
            errors++;
            return;
         end
         e = expected_lines.pop_front();
         checked++;
         if (line_level !== e.line_level) begin
            $error("line_level expected %0b actual %0b", e.line_level, line_level);
            errors++;
         end
         if (busy_res !== e.busy_res) begin
            $error("busy_res expected %0b actual %0b", e.busy_res, busy_res);
            errors++;
         end
         if (done_res !== e.done_res) begin
            $error("done_res expected %0b actual %0b", e.done_res, done_res);
            errors++;
         end
      endfunction

      function int unsigned pending();
         return expected_lines.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic rsp_take = 1'b0;

   pwbs_req_if req_chan ();
   pwbs_rsp_if rsp_chan ();

   assign rsp_chan.ready = rsp_take;

   pulse_width_bit_serializer DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   line_scoreboard sb;
   bit             idle_on = 1'b1;
   int unsigned    effective_count = 0;
   int unsigned    settings_count = 0;
   int unsigned    cycle_count = 0;
   int unsigned    stall_left = 0;

   always #5 clock = ~clock;

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (!idle_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 24);
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL pulse_width_bit_serializer");
         $finish;
      end
   end

   // response sink with random back-pressure
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            sb.check_response(rsp_chan.line_level, rsp_chan.busy_res, rsp_chan.done_res);
         end
         if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_take   <= 1'b0;
         end else begin
            rsp_take   <= 1'b1;
            stall_left <= pick_gap();
         end
      end
   end

   task automatic send_request(op_type op, logic [BYTE_W-1:0] data, logic last);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.func      <= op;
      req_chan.data_byte <= data;
      req_chan.last_byte <= last;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      if (sb.note_request(op, data, last)) effective_count++;
   endtask

   task automatic csr_put(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.write_reg(idx, val);
   endtask

   task automatic apply_config(logic [HIGH_W-1:0] one_high, logic [HIGH_W-1:0] zero_high,
                               logic [HIGH_W-1:0] period, logic [TICK_W-1:0] pause,
                               logic [COUNT_W-1:0] bits);
      csr_put(CSR_ONE_HIGH, CSR_DATA_W'(one_high));
      csr_put(CSR_ZERO_HIGH, CSR_DATA_W'(zero_high));
      csr_put(CSR_PERIOD, CSR_DATA_W'(period));
      csr_put(CSR_PAUSE, CSR_DATA_W'(pause));
      csr_put(CSR_BITS, CSR_DATA_W'(bits));
      csr_we <= 1'b0;
      settings_count++;
   endtask

   task automatic settle_line();
      req_chan.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [BYTE_W-1:0] pick_byte();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0) return 8'h00;
      if (r == 1) return 8'hFF;
      return BYTE_W'($urandom_range(0, 255));
   endfunction

   // ticks until the frame and its pause are out, with stray loads mixed in
   task automatic finish_frame();
      while (sb.phase != PH_IDLE) begin
         if ($urandom_range(0, 9) == 0)
            send_request(OP_LOAD, pick_byte(), 1'($urandom_range(0, 1)));
         else
            send_request(OP_TICK, pick_byte(), 1'($urandom_range(0, 1)));
      end
   endtask

   task automatic run_message(bit broken);
      int unsigned nbytes;
      nbytes = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 16) : $urandom_range(17, 20);
      for (int unsigned k = 0; k < nbytes; k++) begin
         if ($urandom_range(0, 9) == 0)
            send_request(OP_TICK, pick_byte(), 1'($urandom_range(0, 1)));
         send_request(OP_LOAD, pick_byte(), (k == nbytes - 1) && !broken);
      end
      finish_frame();
   endtask

   task automatic loads_only(int unsigned count);
      for (int unsigned k = 0; k < count; k++) begin
         if ($urandom_range(0, 3) == 0)
            send_request(OP_TICK, pick_byte(), 1'($urandom_range(0, 1)));
         send_request(OP_LOAD, pick_byte(), 1'b0);
      end
   endtask

   task automatic random_config();
      logic [HIGH_W-1:0]  one_high;
      logic [HIGH_W-1:0]  zero_high;
      logic [HIGH_W-1:0]  period;
      logic [TICK_W-1:0]  pause;
      logic [COUNT_W-1:0] bits;
      int unsigned        r;
      one_high  = ($urandom_range(0, 9) == 0) ? HIGH_W'($urandom_range(0, 65535))
                                              : HIGH_W'($urandom_range(0, 9));
      zero_high = ($urandom_range(0, 9) == 0) ? HIGH_W'($urandom_range(0, 65535))
                                              : HIGH_W'($urandom_range(0, 9));
      period    = HIGH_W'($urandom_range(0, 10));
      pause     = ($urandom_range(0, 4) == 0) ? TICK_W'($urandom_range(0, 40))
                                              : TICK_W'($urandom_range(0, 10));
      r = $urandom_range(0, 99);
      if (r < 70)      bits = COUNT_W'($urandom_range(1, 24));
      else if (r < 85) bits = COUNT_W'($urandom_range(100, 128));
      else if (r < 92) bits = '0;
      else             bits = COUNT_W'($urandom_range(129, 255));
      apply_config(one_high, zero_high, period, pause, bits);
   endtask

   initial begin
      int unsigned base;
      int unsigned msgs_left;
      sb                 = new();
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.func      = OP_LOAD;
      req_chan.data_byte = '0;
      req_chan.last_byte = 1'b0;
      csr_we             = 1'b0;
      csr_index          = CSR_ONE_HIGH;
      csr_wdata          = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: idle tick, full message store, load while busy
      apply_config(16'd2, 16'd1, 16'd3, 24'd1, 8'd2);
      send_request(OP_TICK, 8'hFF, 1'b1);
      for (int k = 0; k < 16; k++) begin
         send_request(OP_LOAD, (k == 0) ? 8'hFF : (k == 1) ? 8'h00 : pick_byte(), k == 15);
      end
      send_request(OP_LOAD, 8'h5A, 1'b1);
      finish_frame();

      // extreme timing settings
      settle_line();
      apply_config(16'd1, 16'd1, 16'd2, 24'd1, 8'd1);
      repeat (3) run_message(1'b0);
      settle_line();
      apply_config(16'd0, 16'd0, 16'd0, 24'd0, 8'd0);
      repeat (3) run_message(1'b0);
      settle_line();
      apply_config(16'd65535, 16'd65535, 16'd1, 24'd3, 8'd255);
      repeat (2) run_message(1'b0);
      settle_line();
      apply_config(16'd65535, 16'd65535, 16'd65535, 24'd16777215, 8'd128);
      loads_only(20);
      settle_line();
      apply_config(16'd65535, 16'd2, 16'd300, 24'd1, 8'd1);
      idle_on = 1'b0;
      run_message(1'b0);

      base      = effective_count;
      msgs_left = 0;
      while (effective_count < base + RANDOM_ITEMS) begin
         if (msgs_left == 0) begin
            settle_line();
            random_config();
            msgs_left = $urandom_range(2, 4);
         end
         idle_on = ($urandom_range(0, 9) < 7);
         run_message($urandom_range(0, 9) == 0);
         msgs_left--;
      end

      idle_on = 1'b1;
      settle_line();
      $display("%0d requests acted on, %0d responses checked", effective_count, sb.checked);
      $display("%0d frames sent under %0d timing settings", sb.transmissions, settings_count);
      if (sb.errors == 0)
         $display("PASS pulse_width_bit_serializer");
      else
         $display("FAIL pulse_width_bit_serializer");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/pwbs_pkg.sv
hw/rtl/pwbs_if.sv
hw/rtl/pwbs_front.sv
hw/rtl/pwbs_queue.sv
hw/rtl/pwbs_back.sv
hw/rtl/pulse_width_bit_serializer.sv
dv/pulse_width_bit_serializer_tb.sv
